// ----- sv/nearest_free_slot_finder_assert.svh -----
// ----------------------------------------------------------------------------
// Nearest free slot finder assertion macros
// Property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NEAREST_FREE_SLOT_FINDER_ASSERT_SVH
`define NEAREST_FREE_SLOT_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define NFSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define NFSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NFSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define NFSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/nfsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest free slot finder package
// Sizes, command codes and the control and status bundles of the block.
// ----------------------------------------------------------------------------
package nfsf_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int DIST_W    = 20;
    localparam int SUM_W     = 22;

    localparam logic [DIST_W-1:0] NO_DIST = DIST_W'(999999);

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_OCCUPY = 2'd2;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic [9:0] ident;
    } t_entry;

    typedef struct packed {
        logic             capture;
        logic             wr_entry;
        logic             wr_occ;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             pass2;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic have;
    } t_dp_stat;

endpackage

// ----- sv/nfsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Nearest free slot finder controller
// Sequences table writes and the two search passes over the slot table.
// ----------------------------------------------------------------------------
module nfsf_ctrl
    import nfsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_slot_count,
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd,
    output logic        o_busy,
    output logic        o_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_DRAIN1,
        S_PASS2,
        S_DRAIN2,
        S_RESULT
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pass2, n_pass2;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   w_limit;

    always_comb begin
        if (32'(i_slot_count) > MAX_SLOTS) begin
            w_limit = CNT_W'(MAX_SLOTS);
        end else begin
            w_limit = CNT_W'(i_slot_count);
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pass2 = r_pass2;
        n_busy  = r_busy;
        n_done  = 1'b0;

        o_cmd          = '0;
        o_cmd.rd_addr  = r_idx[IDX_W-1:0];
        o_cmd.pass2    = r_pass2;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_busy        = 1'b1;
                    n_idx         = '0;
                    n_pass2       = 1'b0;
                    case (i_command)
                        CMD_QUERY: begin
                            n_state = S_PASS1;
                        end
                        CMD_WRITE: begin
                            o_cmd.wr_entry = 1'b1;
                            n_state        = S_RESULT;
                            n_done         = 1'b1;
                        end
                        CMD_OCCUPY: begin
                            o_cmd.wr_occ = 1'b1;
                            n_state      = S_RESULT;
                            n_done       = 1'b1;
                        end
                        default: begin
                            n_state = S_RESULT;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
            S_PASS1, S_PASS2: begin
                if (r_idx < w_limit) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                end else begin
                    n_state = (r_state == S_PASS1) ? S_DRAIN1 : S_DRAIN2;
                end
            end
            S_DRAIN1: begin
                // The nearby pass decides only once its last entry left the pipeline.
                if (i_stat.pipe_empty) begin
                    if (i_stat.have) begin
                        n_state = S_RESULT;
                        n_done  = 1'b1;
                    end else begin
                        n_state = S_PASS2;
                        n_pass2 = 1'b1;
                        n_idx   = '0;
                    end
                end
            end
            S_DRAIN2: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_RESULT;
                    n_done  = 1'b1;
                end
            end
            S_RESULT: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pass2 <= 1'b0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pass2 <= n_pass2;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ----- sv/nfsf_datapath.sv -----
// ----------------------------------------------------------------------------
// Nearest free slot finder datapath
// Slot table memories, distance pipeline and best-candidate tracking.
// ----------------------------------------------------------------------------
module nfsf_datapath
    import nfsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [5:0]          i_slot_index,
    input  logic [9:0]          i_slot_ident,
    input  logic [9:0]          i_pos_x,
    input  logic [9:0]          i_pos_y,
    input  logic [7:0]          i_size_w,
    input  logic [7:0]          i_size_h,
    input  logic                i_taken_flag,
    input  logic [7:0]          i_search_radius,
    output t_dp_stat            o_stat,
    output logic                o_found,
    output logic [5:0]          o_chosen_index,
    output logic [9:0]          o_chosen_ident,
    output logic [DIST_W-1:0]   o_distance_sq,
    output logic                o_within_radius
);

    // Gap along one axis between [a0,a1] and [b0,b1]; zero when they overlap.
    function automatic logic [10:0] axis_gap(input logic signed [12:0] a0,
                                             input logic signed [12:0] a1,
                                             input logic signed [12:0] b0,
                                             input logic signed [12:0] b1);
        logic signed [12:0] diff;
        begin
            if (a1 < b0) begin
                diff = b0 - a1;
            end else if (a0 > b1) begin
                diff = a0 - b1;
            end else begin
                diff = '0;
            end
            return diff[10:0];
        end
    endfunction

    t_entry             r_entry_mem [MAX_SLOTS];
    logic               r_occ_mem   [MAX_SLOTS];

    logic [9:0]         r_qx, r_qy;
    logic [7:0]         r_qw, r_qh;
    logic [15:0]        r_r2;

    logic               r_v1, r_v2;
    t_entry             r_rd_entry;
    logic               r_rd_occ;
    logic [IDX_W-1:0]   r_idx1, r_idx2;
    logic [9:0]         r_id2;
    logic [20:0]        r_sqx, r_sqy;

    logic               r_have;
    logic [DIST_W-1:0]  r_best_d;
    logic [IDX_W-1:0]   r_best_i;
    logic [9:0]         r_best_id;

    logic               w_idx_ok;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [15:0]        w_r2;
    logic [10:0]        w_gapx, w_gapy, w_opx, w_opy;
    logic [9:0]         w_adx, w_ady;
    logic [20:0]        w_sqx, w_sqy;
    logic [SUM_W-1:0]   w_sum;
    logic               w_take;

    assign w_idx_ok  = 32'(i_slot_index) < MAX_SLOTS;
    assign w_wr_addr = IDX_W'(i_slot_index);
    assign w_r2      = 16'(i_search_radius) * 16'(i_search_radius);

    always_ff @(posedge i_clk) begin
        if (w_idx_ok && i_cmd.wr_entry) begin
            r_entry_mem[w_wr_addr] <= '{x: i_pos_x, y: i_pos_y, w: i_size_w,
                                        h: i_size_h, ident: i_slot_ident};
        end
        if (w_idx_ok && (i_cmd.wr_entry || i_cmd.wr_occ)) begin
            r_occ_mem[w_wr_addr] <= i_taken_flag;
        end
        if (i_cmd.rd_en) begin
            r_rd_entry <= r_entry_mem[i_cmd.rd_addr];
            r_rd_occ   <= r_occ_mem[i_cmd.rd_addr];
        end
    end

    // Stage one: per-axis distance of the entry just read, then its squares.
    always_comb begin
        w_gapx = axis_gap($signed({3'b000, r_qx}),
                          $signed({3'b000, r_qx}) + $signed({5'b00000, r_qw}) - 13'sd1,
                          $signed({3'b000, r_rd_entry.x}),
                          $signed({3'b000, r_rd_entry.x})
                              + $signed({5'b00000, r_rd_entry.w}) - 13'sd1);
        w_gapy = axis_gap($signed({3'b000, r_qy}),
                          $signed({3'b000, r_qy}) + $signed({5'b00000, r_qh}) - 13'sd1,
                          $signed({3'b000, r_rd_entry.y}),
                          $signed({3'b000, r_rd_entry.y})
                              + $signed({5'b00000, r_rd_entry.h}) - 13'sd1);
        w_adx  = (r_rd_entry.x >= r_qx) ? (r_rd_entry.x - r_qx) : (r_qx - r_rd_entry.x);
        w_ady  = (r_rd_entry.y >= r_qy) ? (r_rd_entry.y - r_qy) : (r_qy - r_rd_entry.y);
        w_opx  = i_cmd.pass2 ? {1'b0, w_adx} : w_gapx;
        w_opy  = i_cmd.pass2 ? {1'b0, w_ady} : w_gapy;
    end

    assign w_sqx = 21'(w_opx) * 21'(w_opx);
    assign w_sqy = 21'(w_opy) * 21'(w_opy);

    // Stage two: strict less-than keeps the lowest index on ties.
    assign w_sum  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_take = r_v2 && (w_sum < SUM_W'(NO_DIST)) && (w_sum < SUM_W'(r_best_d))
                    && (i_cmd.pass2 || (w_sum <= SUM_W'(r_r2)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx <= i_pos_x;
            r_qy <= i_pos_y;
            r_qw <= i_size_w;
            r_qh <= i_size_h;
            r_r2 <= w_r2;
        end
        r_idx1 <= i_cmd.rd_addr;
        r_idx2 <= r_idx1;
        r_id2  <= r_rd_entry.ident;
        r_sqx  <= w_sqx;
        r_sqy  <= w_sqy;
        if (i_cmd.capture) begin
            r_best_d  <= NO_DIST;
            r_best_i  <= '0;
            r_best_id <= '0;
        end else if (w_take) begin
            r_best_d  <= w_sum[DIST_W-1:0];
            r_best_i  <= r_idx2;
            r_best_id <= r_id2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1 && !r_rd_occ;
            if (i_cmd.capture) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
        end
    end

    assign o_stat.pipe_empty = !r_v1 && !r_v2;
    assign o_stat.have       = r_have;

    assign o_found         = r_have;
    assign o_chosen_index  = 6'(r_best_i);
    assign o_chosen_ident  = r_best_id;
    assign o_distance_sq   = r_have ? r_best_d : '0;
    assign o_within_radius = r_have && !i_cmd.pass2;

endmodule

// ----- sv/nearest_free_slot_finder.sv -----
// ----------------------------------------------------------------------------
// Nearest free slot finder
// Slot table with a two-pass nearest free slot search.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and it always gives
// exactly one result, shown for one cycle with o_done high; the receiver must
// take it then. A query walks the first slot_count table entries (at most 64)
// one per cycle through a single read port of the slot table; when the nearby
// pass finds nothing the fallback pass walks the table again. Result fields
// are zero for writes and when no slot is chosen. Reset does not clear the
// table.
// ----------------------------------------------------------------------------
module nearest_free_slot_finder
    import nfsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic [5:0]          i_slot_index,
    input  logic [9:0]          i_slot_ident,
    input  logic [9:0]          i_pos_x,
    input  logic [9:0]          i_pos_y,
    input  logic [7:0]          i_size_w,
    input  logic [7:0]          i_size_h,
    input  logic                i_taken_flag,
    output logic                o_done,
    output logic                o_found,
    output logic [5:0]          o_chosen_index,
    output logic [9:0]          o_chosen_ident,
    output logic [DIST_W-1:0]   o_distance_sq,
    output logic                o_within_radius,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    logic [7:0]  r_search_radius;
    logic [6:0]  r_slot_count;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_radius <= 8'd12;
            r_slot_count    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS: r_search_radius <= i_cfg_data;
                CFG_COUNT:  r_slot_count    <= i_cfg_data[6:0];
                default:    r_slot_count    <= r_slot_count;
            endcase
        end
    end

    nfsf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start && !busy),
        .i_command    (i_command),
        .i_slot_count (r_slot_count),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (busy),
        .o_done       (o_done)
    );

    nfsf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_slot_index    (i_slot_index),
        .i_slot_ident    (i_slot_ident),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_size_w        (i_size_w),
        .i_size_h        (i_size_h),
        .i_taken_flag    (i_taken_flag),
        .i_search_radius (r_search_radius),
        .o_stat          (w_stat),
        .o_found         (o_found),
        .o_chosen_index  (o_chosen_index),
        .o_chosen_ident  (o_chosen_ident),
        .o_distance_sq   (o_distance_sq),
        .o_within_radius (o_within_radius)
    );

`include "nearest_free_slot_finder_assert.svh"

    `NFSF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy did not rise after a transfer")
    `NFSF_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe lasted more than one cycle")
    `NFSF_ASSERT_NOW(a_near_found, i_clk, i_rst_n, o_done && o_within_radius, o_found, "nearby flag without a chosen slot")
    `NFSF_ASSERT_NOW(a_dist_range, i_clk, i_rst_n, o_done && o_found, o_distance_sq < NO_DIST, "chosen distance out of range")

endmodule

// ----- verif/nfsf_slot_checker.sv -----
// ----------------------------------------------------------------------------
// Nearest free slot finder checker
// Watches the command, result and register ports of the block. It keeps its
// own copy of the slot table and registers, predicts the result of every
// accepted command, and compares each result transfer with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module nfsf_slot_checker
    import nfsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_command,
    input  logic [5:0]        i_slot_index,
    input  logic [9:0]        i_slot_ident,
    input  logic [9:0]        i_pos_x,
    input  logic [9:0]        i_pos_y,
    input  logic [7:0]        i_size_w,
    input  logic [7:0]        i_size_h,
    input  logic              i_taken_flag,
    input  logic              i_done,
    input  logic              i_found,
    input  logic [5:0]        i_chosen_index,
    input  logic [9:0]        i_chosen_ident,
    input  logic [DIST_W-1:0] i_distance_sq,
    input  logic              i_within_radius,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output int                o_mismatches,
    output int                o_pending
);

    typedef struct packed {
        logic              found;
        logic [5:0]        index;
        logic [9:0]        ident;
        logic [DIST_W-1:0] distance;
        logic              nearby;
    } t_slot_choice;

    logic [9:0] anchor_x_tab [MAX_SLOTS];
    logic [9:0] anchor_y_tab [MAX_SLOTS];
    logic [7:0] width_tab    [MAX_SLOTS];
    logic [7:0] height_tab   [MAX_SLOTS];
    logic [9:0] ident_tab    [MAX_SLOTS];
    logic       taken_tab    [MAX_SLOTS];

    logic [7:0]   radius_reg;
    logic [6:0]   count_reg;
    t_slot_choice expected_choices [$];
    int           mismatch_count = 0;

    // Gap along one axis between [a0,a1] and [b0,b1], zero when they overlap.
    function automatic int axis_gap(int a0, int a1, int b0, int b1);
        if (a1 < b0) begin
            return b0 - a1;
        end
        if (a0 > b1) begin
            return a0 - b1;
        end
        return 0;
    endfunction

    function automatic t_slot_choice pick_free_slot(int qx, int qy, int qw, int qh);
        t_slot_choice choice;
        int           n;
        int           r2;
        int           best_d;
        int           best_i;
        int           px;
        int           py;
        int           dx;
        int           dy;
        int           d;
        bit           have;
        bit           nearby;
        choice = '0;
        n      = (count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg);
        r2     = int'(radius_reg) * int'(radius_reg);
        best_d = int'(NO_DIST);
        best_i = 0;
        have   = 1'b0;
        nearby = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!taken_tab[i]) begin
                px = int'(anchor_x_tab[i]);
                py = int'(anchor_y_tab[i]);
                dx = axis_gap(qx, qx + qw - 1, px, px + int'(width_tab[i]) - 1);
                dy = axis_gap(qy, qy + qh - 1, py, py + int'(height_tab[i]) - 1);
                d  = dx * dx + dy * dy;
                if (d <= r2 && d < best_d) begin
                    best_d = d;
                    best_i = i;
                    have   = 1'b1;
                end
            end
        end
        if (have) begin
            nearby = 1'b1;
        end else begin
            // Nothing close enough: fall back to the nearest anchor.
            best_d = int'(NO_DIST);
            for (int i = 0; i < n; i++) begin
                if (!taken_tab[i]) begin
                    dx = int'(anchor_x_tab[i]) - qx;
                    dy = int'(anchor_y_tab[i]) - qy;
                    d  = dx * dx + dy * dy;
                    if (d < best_d) begin
                        best_d = d;
                        best_i = i;
                        have   = 1'b1;
                    end
                end
            end
        end
        if (have) begin
            choice.found    = 1'b1;
            choice.index    = best_i[5:0];
            choice.ident    = ident_tab[best_i];
            choice.distance = best_d[DIST_W-1:0];
            choice.nearby   = nearby;
        end
        return choice;
    endfunction

    // Applies one accepted command to the table and gives its expected result.
    function automatic t_slot_choice run_command();
        t_slot_choice choice;
        choice = '0;
        case (i_command)
            CMD_WRITE: begin
                if (i_slot_index < MAX_SLOTS) begin
                    anchor_x_tab[i_slot_index] = i_pos_x;
                    anchor_y_tab[i_slot_index] = i_pos_y;
                    width_tab[i_slot_index]    = i_size_w;
                    height_tab[i_slot_index]   = i_size_h;
                    ident_tab[i_slot_index]    = i_slot_ident;
                    taken_tab[i_slot_index]    = i_taken_flag;
                end
            end
            CMD_OCCUPY: begin
                if (i_slot_index < MAX_SLOTS) begin
                    taken_tab[i_slot_index] = i_taken_flag;
                end
            end
            CMD_QUERY: begin
                choice = pick_free_slot(int'(i_pos_x), int'(i_pos_y),
                                        int'(i_size_w), int'(i_size_h));
            end
            default: begin
            end
        endcase
        return choice;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_choice want;
        if (!i_rst_n) begin
            radius_reg = 8'd12;
            count_reg  = 7'd0;
            expected_choices.delete();
        end else begin
            if (i_done) begin
                if (expected_choices.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_choices.pop_front();
                    check_field("found", want.found, i_found);
                    check_field("chosen_index", want.index, i_chosen_index);
                    check_field("chosen_ident", want.ident, i_chosen_ident);
                    check_field("distance_sq", want.distance, i_distance_sq);
                    check_field("within_radius", want.nearby, i_within_radius);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RADIUS) begin
                    radius_reg = i_cfg_data;
                end else begin
                    count_reg = i_cfg_data[6:0];
                end
            end
            if (i_start && !i_busy) begin
                expected_choices.push_back(run_command());
            end
        end
        o_pending    <= expected_choices.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ----- verif/tb_nearest_free_slot_finder.sv -----
// ----------------------------------------------------------------------------
// Nearest free slot finder testbench
// Drives a directed set of commands covering the field extremes, zero sizes,
// ties, the radius limits and queries that find nothing, then fills the
// whole table and runs random command mixes over several register settings
// and sender idling rates. The checker beside the block does the prediction.
// ----------------------------------------------------------------------------
module tb_nearest_free_slot_finder;
    import nfsf_pkg::*;

    // Command code the block does not define; it must answer with all zeros.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_command = CMD_QUERY;
    logic [5:0]        i_slot_index = '0;
    logic [9:0]        i_slot_ident = '0;
    logic [9:0]        i_pos_x = '0;
    logic [9:0]        i_pos_y = '0;
    logic [7:0]        i_size_w = 8'd1;
    logic [7:0]        i_size_h = 8'd1;
    logic              i_taken_flag = 1'b0;
    logic              o_done;
    logic              o_found;
    logic [5:0]        o_chosen_index;
    logic [9:0]        o_chosen_ident;
    logic [DIST_W-1:0] o_distance_sq;
    logic              o_within_radius;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = CFG_RADIUS;
    logic [7:0]        i_cfg_data = '0;

    int mismatches;
    int pending;
    int sender_idle_pct = 16;
    int cluster_base = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    nearest_free_slot_finder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_slot_index    (i_slot_index),
        .i_slot_ident    (i_slot_ident),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_size_w        (i_size_w),
        .i_size_h        (i_size_h),
        .i_taken_flag    (i_taken_flag),
        .o_done          (o_done),
        .o_found         (o_found),
        .o_chosen_index  (o_chosen_index),
        .o_chosen_ident  (o_chosen_ident),
        .o_distance_sq   (o_distance_sq),
        .o_within_radius (o_within_radius),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    nfsf_slot_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_command       (i_command),
        .i_slot_index    (i_slot_index),
        .i_slot_ident    (i_slot_ident),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_size_w        (i_size_w),
        .i_size_h        (i_size_h),
        .i_taken_flag    (i_taken_flag),
        .i_done          (o_done),
        .i_found         (o_found),
        .i_chosen_index  (o_chosen_index),
        .i_chosen_ident  (o_chosen_ident),
        .i_distance_sq   (o_distance_sq),
        .i_within_radius (o_within_radius),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // Start stays high across back-to-back commands; it only drops for a gap.
    task automatic send_command(logic [1:0] cmd, int idx, int ident, int x, int y,
                                int w, int h, bit taken);
        start        <= 1'b1;
        i_command    <= cmd;
        i_slot_index <= idx[5:0];
        i_slot_ident <= ident[9:0];
        i_pos_x      <= x[9:0];
        i_pos_y      <= y[9:0];
        i_size_w     <= w[7:0];
        i_size_h     <= h[7:0];
        i_taken_flag <= taken;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_search_config(int radius, int count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RADIUS;
        i_cfg_data  <= radius[7:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= count[7:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Most positions land in one cluster so that the nearby pass gets hits.
    function automatic int rand_pos();
        if ($urandom_range(9) < 6) begin
            return cluster_base + $urandom_range(127);
        end
        return $urandom_range(1023);
    endfunction

    function automatic int rand_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return $urandom_range(1, 32);
        end
        if (pick < 95) begin
            return $urandom_range(255);
        end
        return (pick < 97) ? 0 : 255;
    endfunction

    task automatic random_command();
        int         pick;
        logic [1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 55) begin
            cmd = CMD_QUERY;
        end else if (pick < 80) begin
            cmd = CMD_WRITE;
        end else if (pick < 95) begin
            cmd = CMD_OCCUPY;
        end else begin
            cmd = CMD_UNUSED;
        end
        send_command(cmd, $urandom_range(63), $urandom_range(1023), rand_pos(), rand_pos(),
                     rand_size(), rand_size(),
                     $urandom_range(99) < ((cmd == CMD_OCCUPY) ? 50 : 30));
    endtask

    initial begin
        int radius;
        int count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table in use: nothing to choose. Then the undefined command.
        send_command(CMD_QUERY, 0, 0, 500, 500, 10, 10, 1'b0);
        send_command(CMD_UNUSED, 63, 1023, 1023, 1023, 255, 255, 1'b1);
        // Slots two and three share an anchor; slot two has zero size.
        send_command(CMD_WRITE, 0, 0, 0, 0, 1, 1, 1'b0);
        send_command(CMD_WRITE, 1, 1023, 1023, 1023, 255, 255, 1'b1);
        send_command(CMD_WRITE, 2, 682, 100, 100, 0, 0, 1'b0);
        send_command(CMD_WRITE, 3, 341, 100, 100, 20, 20, 1'b0);
        send_command(CMD_WRITE, 63, 77, 512, 512, 8, 8, 1'b1);
        send_command(CMD_OCCUPY, 1, 0, 0, 0, 1, 1, 1'b0);
        send_command(CMD_OCCUPY, 0, 0, 0, 0, 1, 1, 1'b1);
        wait_drained();
        set_search_config(12, 4);
        send_command(CMD_QUERY, 0, 0, 110, 110, 5, 5, 1'b0);
        send_command(CMD_QUERY, 0, 0, 1023, 1023, 255, 255, 1'b0);
        send_command(CMD_OCCUPY, 1, 0, 0, 0, 1, 1, 1'b1);
        send_command(CMD_OCCUPY, 3, 0, 0, 0, 1, 1, 1'b1);
        // Every free slot is too far for either pass.
        send_command(CMD_QUERY, 0, 0, 1023, 1023, 1, 1, 1'b0);
        send_command(CMD_OCCUPY, 0, 0, 0, 0, 1, 1, 1'b0);
        send_command(CMD_QUERY, 0, 0, 1000, 0, 1, 1, 1'b0);
        send_command(CMD_OCCUPY, 3, 0, 0, 0, 1, 1, 1'b0);
        // Equal anchor distances: the lower index must win.
        send_command(CMD_QUERY, 0, 0, 300, 300, 1, 1, 1'b0);
        wait_drained();
        set_search_config(0, 4);
        send_command(CMD_QUERY, 0, 0, 0, 0, 1, 1, 1'b0);
        send_command(CMD_QUERY, 0, 0, 1, 0, 1, 1, 1'b0);
        wait_drained();
        set_search_config(255, 4);
        send_command(CMD_QUERY, 0, 0, 250, 250, 1, 1, 1'b0);

        // Fill the whole table so that any slot count is safe to query.
        cluster_base = $urandom_range(896);
        for (int i = 0; i < MAX_SLOTS; i++) begin
            send_command(CMD_WRITE, i, $urandom_range(1023), rand_pos(), rand_pos(),
                         rand_size(), rand_size(), $urandom_range(99) < 30);
        end

        for (int mode = 0; mode < 3; mode++) begin
            sender_idle_pct = (mode == 0) ? 16 : ((mode == 1) ? 65 : 0);
            for (int phase = 0; phase < 4; phase++) begin
                case ((phase + mode) % 4)
                    0:       radius = 0;
                    1:       radius = 255;
                    2:       radius = 12;
                    default: radius = $urandom_range(255);
                endcase
                case (phase)
                    0:       count = MAX_SLOTS;
                    1:       count = $urandom_range(1, 8);
                    2:       count = 127;
                    default: count = $urandom_range(127);
                endcase
                wait_drained();
                cluster_base = $urandom_range(896);
                set_search_config(radius, count);
                repeat (117) random_command();
            end
        end

        wait_drained();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_nearest_free_slot_finder: clean");
        end else begin
            $display("tb_nearest_free_slot_finder: errors");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_nearest_free_slot_finder: errors");
        $finish;
    end

endmodule
